@@ rtl/ilffa_pkg.sv @@
package ilffa_pkg;

   // Field widths fixed by the item format
   localparam int MODE_W = 2;
   localparam int LEN_W  = 12;
   localparam int SIZE_W = 12;
   localparam int PAY_W  = 12;
   // roundup8(length + 4) of a 12-bit length needs one more bit
   localparam int NEED_W = 13;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_FORMAT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_COALESCE = 2'd3;

   // Heap size register after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd4084;

   // Header memory read address source
   typedef enum logic [1:0] {
      ADDR_CUR,
      ADDR_NEXT,
      ADDR_FREE
   } addr_sel_type;

   // Header memory write kinds
   typedef enum logic [2:0] {
      WR_NONE,
      WR_FORMAT,
      WR_TAKE,
      WR_SPLIT,
      WR_MERGE,
      WR_FREE
   } wr_op_type;

   // Controller to datapath
   typedef struct packed {
      logic         load;
      logic         fmt;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         hv_rd;
      logic         hdr_ld;
      logic         advance;
      logic         merge;
      wr_op_type    wr_op;
      logic         rsp;
      logic         rsp_ok;
      logic         rsp_pay;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic formatted;
      logic walk_ok;
      logic sz_zero;
      logic fits;
      logic exact;
      logic next_end;
      logic pair_free;
      logic free_ok;
   } status_type;

endpackage

@@ rtl/ilffa_ctrl.sv @@
module ilffa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ilffa_pkg::MODE_W-1:0]  req_mode,
   output logic                          busy,
   output ilffa_pkg::cmd_type            cmd,
   input  ilffa_pkg::status_type         sts
);
   import ilffa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FMT,
      S_FAIL,
      S_A_RD,
      S_A_EVAL,
      S_A_SPLIT,
      S_C_RD,
      S_C_FIRST,
      S_C_CHECK,
      S_C_PAIR,
      S_F_RD,
      S_F_WR
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               priority if (req_mode == MODE_FORMAT) state_in = S_FMT;
               else if (!sts.formatted)             state_in = S_FAIL;
               else if (req_mode == MODE_ALLOC)     state_in = S_A_RD;
               else if (req_mode == MODE_FREE)      state_in = S_F_RD;
               else                                 state_in = S_C_RD;
            end
         end
         S_FMT: begin
            cmd.fmt    = 1'b1;
            cmd.wr_op  = WR_FORMAT;
            cmd.rsp    = 1'b1;
            cmd.rsp_ok = 1'b1;
            state_in   = S_IDLE;
         end
         S_FAIL: begin
            cmd.rsp  = 1'b1;
            state_in = S_IDLE;
         end
         // allocate: one header per cycle, next read issued from current header
         S_A_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_CUR;
            state_in     = S_A_EVAL;
         end
         S_A_EVAL: begin
            cmd.hv_rd = 1'b1;
            priority if (!sts.walk_ok || sts.sz_zero) begin
               cmd.rsp  = 1'b1;
               state_in = S_IDLE;
            end else if (sts.fits) begin
               cmd.wr_op = WR_TAKE;
               if (sts.exact) begin
                  cmd.rsp     = 1'b1;
                  cmd.rsp_ok  = 1'b1;
                  cmd.rsp_pay = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_A_SPLIT;
               end
            end else begin
               cmd.advance  = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_NEXT;
            end
         end
         S_A_SPLIT: begin
            cmd.hv_rd   = 1'b1;
            cmd.wr_op   = WR_SPLIT;
            cmd.rsp     = 1'b1;
            cmd.rsp_ok  = 1'b1;
            cmd.rsp_pay = 1'b1;
            state_in    = S_IDLE;
         end
         // coalesce: current header cached, neighbor read each step
         S_C_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_CUR;
            state_in     = S_C_FIRST;
         end
         S_C_FIRST, S_C_CHECK: begin
            cmd.hv_rd  = (state_ff == S_C_FIRST);
            cmd.hdr_ld = (state_ff == S_C_FIRST);
            if (!sts.walk_ok || sts.sz_zero || sts.next_end) begin
               cmd.rsp    = 1'b1;
               cmd.rsp_ok = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_NEXT;
               state_in     = S_C_PAIR;
            end
         end
         S_C_PAIR: begin
            if (sts.pair_free) begin
               cmd.merge = 1'b1;
               cmd.wr_op = WR_MERGE;
            end else begin
               cmd.advance = 1'b1;
               cmd.hdr_ld  = 1'b1;
            end
            state_in = S_C_CHECK;
         end
         // free: read-modify-write of one header
         S_F_RD: begin
            if (!sts.free_ok) begin
               cmd.rsp  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_FREE;
               state_in     = S_F_WR;
            end
         end
         S_F_WR: begin
            cmd.wr_op  = WR_FREE;
            cmd.rsp    = 1'b1;
            cmd.rsp_ok = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/ilffa_dpath.sv @@
module ilffa_dpath #(
   parameter int HEAP_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ilffa_pkg::LEN_W-1:0]   req_length,
   input  logic [ilffa_pkg::LEN_W-1:0]   req_free_pointer,
   input  logic                          csr_write_enable,
   input  logic [ilffa_pkg::SIZE_W-1:0]  csr_requested_size,
   input  ilffa_pkg::cmd_type            cmd,
   output ilffa_pkg::status_type         sts,
   output logic                          rsp_valid,
   output logic                          rsp_success,
   output logic [ilffa_pkg::PAY_W-1:0]   rsp_payload_offset
);
   import ilffa_pkg::*;

   localparam int SLOTS      = HEAP_BYTES / 8;
   localparam int HEAP_LIMIT = (HEAP_BYTES / 8) * 8;
   localparam int AW         = $clog2(HEAP_BYTES + 1);
   localparam int PW         = AW + 1;
   localparam int HW         = AW;
   localparam int IW         = $clog2(SLOTS);
   localparam int GW         = $clog2(SLOTS + 1);
   localparam int CW         = (PW > NEED_W) ? PW : NEED_W;

   logic [HW-1:0]     hdr_mem [SLOTS];
   logic [HW-1:0]     rd_data_ff;

   logic [PW-1:0]     cur_ff;
   logic [HW-1:0]     hdr_ff;
   logic [GW-1:0]     guard_ff;
   logic [NEED_W-1:0] need_ff;
   logic [LEN_W-1:0]  fp_ff;
   logic [AW-1:0]     heap_end_ff;
   logic              formatted_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              rsp_valid_ff;
   logic              rsp_success_ff;
   logic [PAY_W-1:0]  rsp_pay_ff;

   logic [HW-1:0]     hv;
   logic [CW-1:0]     sz_w;
   logic [CW-1:0]     cur_w;
   logic [CW-1:0]     end_w;
   logic [CW-1:0]     need_w;
   logic [CW-1:0]     next_w;
   logic [CW-1:0]     split_w;
   logic [CW-1:0]     fhdr_w;
   logic [CW-1:0]     merge_w;
   logic [CW-1:0]     a_raw;
   logic [CW-1:0]     a_w;
   logic [CW-1:0]     pay_w;
   logic [NEED_W-1:0] need_in;
   logic [CW-1:0]     rd_ptr;
   logic [CW-1:0]     wr_ptr;
   logic [HW-1:0]     wr_val;
   logic              wr_en;
   logic [IW-1:0]     rd_idx;
   logic [IW-1:0]     wr_idx;

   // Header under evaluation: fresh read data or the cached copy
   assign hv      = cmd.hv_rd ? rd_data_ff : hdr_ff;
   assign sz_w    = CW'({hv[HW-1:3], 3'b000});
   assign cur_w   = CW'(cur_ff);
   assign end_w   = CW'(heap_end_ff);
   assign need_w  = CW'(need_ff);
   assign next_w  = cur_w + sz_w;
   assign split_w = cur_w + need_w;
   // header sits 4 bytes before the payload
   assign fhdr_w  = CW'(fp_ff) - CW'(4);
   assign merge_w = CW'({hdr_ff[HW-1:3], 3'b000}) + CW'({rd_data_ff[HW-1:3], 3'b000});
   assign pay_w   = cur_w + CW'(4);

   // Format extent: roundup8(size + 12), clamped to the heap
   assign a_raw = (CW'(size_ff) + CW'(19)) & ~CW'(7);
   assign a_w   = (a_raw > CW'(HEAP_LIMIT)) ? CW'(HEAP_LIMIT) : a_raw;

   // Allocation unit: roundup8(length + 4)
   assign need_in = (NEED_W'(req_length) + NEED_W'(11)) & ~NEED_W'(7);

   // Status to the controller
   always_comb begin
      sts.formatted = formatted_ff;
      sts.walk_ok   = (guard_ff < GW'(SLOTS)) && (cur_w < end_w);
      sts.sz_zero   = (sz_w == '0);
      sts.fits      = !hv[0] && (sz_w >= need_w);
      sts.exact     = (sz_w == need_w);
      sts.next_end  = (next_w >= end_w);
      sts.pair_free = !hdr_ff[0] && !rd_data_ff[0];
      // below heap_end also keeps the slot inside the memory
      sts.free_ok   = (fp_ff[2:0] == 3'd0) && (fp_ff >= LEN_W'(8)) && (fhdr_w < end_w);
   end

   // Read address
   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_CUR:  rd_ptr = cur_w;
         ADDR_NEXT: rd_ptr = next_w;
         ADDR_FREE: rd_ptr = fhdr_w;
         default:   rd_ptr = cur_w;
      endcase
   end
   assign rd_idx = rd_ptr[IW+2:3];

   // Write port
   always_comb begin
      wr_en  = 1'b0;
      wr_ptr = cur_w;
      wr_val = hdr_ff;
      unique case (cmd.wr_op)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_FORMAT: begin
            wr_en  = 1'b1;
            wr_ptr = CW'(4);
            wr_val = HW'(a_w - CW'(8));
         end
         WR_TAKE: begin
            wr_en  = 1'b1;
            wr_val = HW'(need_w | CW'(1));
         end
         WR_SPLIT: begin
            wr_en  = (split_w < end_w);
            wr_ptr = split_w;
            wr_val = HW'(sz_w - need_w);
         end
         WR_MERGE: begin
            wr_en  = 1'b1;
            wr_val = HW'(merge_w);
         end
         WR_FREE: begin
            wr_en  = 1'b1;
            wr_ptr = fhdr_w;
            wr_val = {rd_data_ff[HW-1:1], 1'b0};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end
   assign wr_idx = wr_ptr[IW+2:3];

   // Header memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_idx] <= wr_val;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= hdr_mem[rd_idx];
      end
   end

   // Heap state, size register, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_end_ff  <= '0;
         formatted_ff <= 1'b0;
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            size_ff <= csr_requested_size;
         end
         if (cmd.fmt) begin
            heap_end_ff  <= AW'(a_w - CW'(4));
            formatted_ff <= 1'b1;
         end
         rsp_valid_ff <= cmd.rsp;
      end
   end

   // Walk registers and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff   <= PW'(4);
         guard_ff <= '0;
         need_ff  <= need_in;
         fp_ff    <= req_free_pointer;
      end else begin
         if (cmd.advance) begin
            cur_ff <= next_w[PW-1:0];
         end
         if (cmd.advance || cmd.merge) begin
            guard_ff <= guard_ff + GW'(1);
         end
      end
      if (cmd.merge) begin
         hdr_ff <= HW'(merge_w);
      end else if (cmd.hdr_ld) begin
         hdr_ff <= rd_data_ff;
      end
      if (cmd.rsp) begin
         rsp_success_ff <= cmd.rsp_ok;
         rsp_pay_ff     <= cmd.rsp_pay ? pay_w[PAY_W-1:0] : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = rsp_success_ff;
   assign rsp_payload_offset = rsp_pay_ff;

endmodule

@@ rtl/implicit_list_first_fit_allocator_unit.sv @@
// Start accept to rsp_valid: format runs S_FMT, unformatted S_FAIL, free S_F_RD and S_F_WR
// (a bad free ends in S_F_RD), allocate S_A_RD, S_A_EVAL per block, S_A_SPLIT on a split,
// coalesce S_C_RD, S_C_FIRST, then S_C_PAIR and S_C_CHECK per step (up to HEAP_BYTES/8 steps).
// One item at a time; busy stays high until the result strobe is issued.
// Sync active-high reset: heap unformatted, size register 4084, header memory not cleared.
// rsp_valid is a one-cycle strobe; the receiver cannot stall.
module implicit_list_first_fit_allocator_unit #(
   parameter int HEAP_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ilffa_pkg::MODE_W-1:0]  req_mode,
   input  logic [ilffa_pkg::LEN_W-1:0]   req_length,
   input  logic [ilffa_pkg::LEN_W-1:0]   req_free_pointer,
   output logic                          rsp_valid,
   output logic                          rsp_success,
   output logic [ilffa_pkg::PAY_W-1:0]   rsp_payload_offset,
   input  logic                          csr_write_enable,
   input  logic [ilffa_pkg::SIZE_W-1:0]  csr_requested_size
);
   import ilffa_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // Operation sequencer
   ilffa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .cmd      (cmd),
      .sts      (sts)
   );

   // Header memory and walk datapath
   ilffa_dpath #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_length         (req_length),
      .req_free_pointer   (req_free_pointer),
      .csr_write_enable   (csr_write_enable),
      .csr_requested_size (csr_requested_size),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_success        (rsp_success),
      .rsp_payload_offset (rsp_payload_offset)
   );

`ifndef SYNTHESIS
   // accepted item keeps the unit busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting an item");

   // a result only ends a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding busy cycle");

   // failures carry a zero offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |-> (rsp_payload_offset == '0))
      else $error("failed item with nonzero payload offset");

   // payloads start on an 8-byte boundary
   a_pay_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload_offset[2:0] == 3'd0))
      else $error("misaligned payload offset");
`endif

endmodule

@@ verif/ilffa_checker.sv @@
`timescale 1ns / 1ps

module ilffa_checker #(
   parameter int HEAP_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [ilffa_pkg::MODE_W-1:0]  req_mode,
   input  logic [ilffa_pkg::LEN_W-1:0]   req_length,
   input  logic [ilffa_pkg::LEN_W-1:0]   req_free_pointer,
   input  logic                          rsp_valid,
   input  logic                          rsp_success,
   input  logic [ilffa_pkg::PAY_W-1:0]   rsp_payload_offset,
   input  logic                          csr_write_enable,
   input  logic [ilffa_pkg::SIZE_W-1:0]  csr_requested_size,
   output int                            errors = 0,
   output int                            pending = 0
);
   import ilffa_pkg::*;

   localparam int SLOTS      = HEAP_BYTES / 8;
   localparam int HEAP_LIMIT = HEAP_BYTES & ~7;

   typedef struct packed {
      logic             success;
      logic [PAY_W-1:0] offset;
   } heap_reply_type;

   // Shadow heap: one header per 8-byte slot at offset 8*i+4
   logic [13:0]       headers [SLOTS];
   logic [12:0]       heap_end;
   bit                heap_formatted;
   logic [SIZE_W-1:0] heap_size;
   heap_reply_type    expected_replies [$];

   initial begin
      foreach (headers[i]) headers[i] = '0;
   end

   function automatic bit header_slot(input int h, output int idx);
      idx = h >> 3;
      return (h % 8 == 4) && (h < heap_end) && (idx < SLOTS);
   endfunction

   function automatic int header_get(input int h);
      int idx;
      if (!header_slot(h, idx)) return 0;
      return int'(headers[idx]);
   endfunction

   function automatic void header_put(input int h, input int v);
      int idx;
      if (header_slot(h, idx)) headers[idx] = 14'(v);
   endfunction

   // Apply one operation to the shadow heap and return its result
   function automatic heap_reply_type run_heap_op(input logic [MODE_W-1:0] mode,
                                                  input logic [LEN_W-1:0]  len,
                                                  input logic [LEN_W-1:0]  fp);
      int             a, need, h, sz, hv, nh, nv, guard, idx;
      bit             walking;
      heap_reply_type reply;
      reply = '0;
      if (mode == MODE_FORMAT) begin
         a = (int'(heap_size) + 12 + 7) & ~7;
         if (a > HEAP_LIMIT) a = HEAP_LIMIT;
         heap_end = 13'(a - 4);
         heap_formatted = 1'b1;
         header_put(4, a - 8);
         reply.success = 1'b1;
      end else if (!heap_formatted) begin
         reply = '0;
      end else if (mode == MODE_ALLOC) begin
         // first fit: take exact fit or split off the front
         need = (int'(len) + 4 + 7) & ~7;
         h = 4;
         walking = 1'b1;
         for (guard = 0; guard < SLOTS && h < heap_end && walking; guard++) begin
            hv = header_get(h);
            sz = hv & ~7;
            if (sz == 0) begin
               walking = 1'b0;
            end else if ((hv & 1) == 0 && sz >= need) begin
               header_put(h, need | 1);
               if (sz > need) header_put(h + need, sz - need);
               reply.success = 1'b1;
               reply.offset  = PAY_W'(h + 4);
               walking = 1'b0;
            end else begin
               h += sz;
            end
         end
      end else if (mode == MODE_FREE) begin
         if (fp[2:0] == 3'd0 && fp >= 8 && header_slot(int'(fp) - 4, idx)) begin
            headers[idx][0] = 1'b0;
            reply.success = 1'b1;
         end
      end else begin
         // merge each free block with the free blocks right after it
         h = 4;
         walking = 1'b1;
         for (guard = 0; guard < SLOTS && h < heap_end && walking; guard++) begin
            hv = header_get(h);
            sz = hv & ~7;
            nh = h + sz;
            if (sz == 0 || nh >= heap_end) begin
               walking = 1'b0;
            end else begin
               nv = header_get(nh);
               if ((hv & 1) == 0 && (nv & 1) == 0) header_put(h, sz + (nv & ~7));
               else h = nh;
            end
         end
         reply.success = 1'b1;
      end
      return reply;
   endfunction

   // Compare results, track register writes, predict accepted items
   always @(posedge clock) begin
      heap_reply_type want;
      int             fails;
      fails = 0;
      if (reset) begin
         heap_end       = '0;
         heap_formatted = 1'b0;
         heap_size      = SIZE_RESET;
         expected_replies.delete();
         pending <= 0;
      end else begin
         if (rsp_valid !== 1'b0) begin
            if (expected_replies.size() == 0) begin
               $error("result strobe with no item outstanding");
               fails++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_success !== want.success) begin
                  $error("success: expected %0d, got %0d", want.success, rsp_success);
                  fails++;
               end
               if (rsp_payload_offset !== want.offset) begin
                  $error("payload_offset: expected %0d, got %0d", want.offset,
                         rsp_payload_offset);
                  fails++;
               end
            end
         end
         if (csr_write_enable) heap_size = csr_requested_size;
         if (start && !busy) begin
            expected_replies.push_back(run_heap_op(req_mode, req_length, req_free_pointer));
         end
         errors  <= errors + fails;
         pending <= expected_replies.size();
      end
   end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import ilffa_pkg::*;

   localparam int HEAP_BYTES = 4096;
   localparam int PTR_RING   = 128;
   localparam int PHASES     = 6;
   localparam int PHASE_ITEMS = 290;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [MODE_W-1:0] req_mode = MODE_FORMAT;
   logic [LEN_W-1:0]  req_length = '0;
   logic [LEN_W-1:0]  req_free_pointer = '0;
   logic              rsp_valid;
   logic              rsp_success;
   logic [PAY_W-1:0]  rsp_payload_offset;
   logic              csr_write_enable = 1'b0;
   logic [SIZE_W-1:0] csr_requested_size = SIZE_RESET;

   int errors;
   int pending;

   int idle_pct = 0;
   int size_now = int'(SIZE_RESET);
   int heap_top = 0;

   // payloads handed out by allocates; their headers are known to be written
   logic [PAY_W-1:0] ptr_ring [PTR_RING];
   int               ptr_total = 0;

   always #5 clock = ~clock;

   implicit_list_first_fit_allocator_unit #(
      .HEAP_BYTES(HEAP_BYTES)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_length        (req_length),
      .req_free_pointer  (req_free_pointer),
      .rsp_valid         (rsp_valid),
      .rsp_success       (rsp_success),
      .rsp_payload_offset(rsp_payload_offset),
      .csr_write_enable  (csr_write_enable),
      .csr_requested_size(csr_requested_size)
   );

   ilffa_checker #(
      .HEAP_BYTES(HEAP_BYTES)
   ) u_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_length        (req_length),
      .req_free_pointer  (req_free_pointer),
      .rsp_valid         (rsp_valid),
      .rsp_success       (rsp_success),
      .rsp_payload_offset(rsp_payload_offset),
      .csr_write_enable  (csr_write_enable),
      .csr_requested_size(csr_requested_size),
      .errors            (errors),
      .pending           (pending)
   );

   // collect allocated payloads into the ring through nonblocking writes
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_success === 1'b1 && rsp_payload_offset != '0) begin
         ptr_ring[ptr_total % PTR_RING] <= rsp_payload_offset;
         ptr_total <= ptr_total + 1;
      end
   end

   // present one item, idling first at random, and hold it until accepted
   task automatic issue(input logic [MODE_W-1:0] mode, input int len, input int fp);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_mode         <= mode;
      req_length       <= LEN_W'(len);
      req_free_pointer <= LEN_W'(fp);
      if (mode == MODE_FORMAT) begin
         heap_top = (size_now + 12 + 7) & ~7;
         if (heap_top > (HEAP_BYTES & ~7)) heap_top = HEAP_BYTES & ~7;
         heap_top -= 4;
      end
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy !== 1'b0);
   endtask

   task automatic write_size(input int v);
      settle();
      repeat (4) @(posedge clock);
      csr_write_enable   <= 1'b1;
      csr_requested_size <= SIZE_W'(v);
      size_now = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly allocate/free traffic on live blocks, with some bad frees
   task automatic issue_random();
      int                pick, len, fp, lim;
      logic [MODE_W-1:0] mode;
      pick = $urandom_range(0, 99);
      len  = $urandom_range(0, 4095);
      fp   = $urandom_range(0, 4095);
      if (pick < 4) begin
         mode = MODE_FORMAT;
      end else if (pick < 50) begin
         mode = MODE_ALLOC;
         case ($urandom_range(0, 9))
            7, 8: len = $urandom_range(0, 400);
            9: len = $urandom_range(0, 4095);
            default: len = $urandom_range(0, 60);
         endcase
      end else if (pick < 84) begin
         mode = MODE_FREE;
         pick = $urandom_range(0, 19);
         lim  = (ptr_total < PTR_RING) ? ptr_total : PTR_RING;
         if (pick < 15) begin
            fp = (lim == 0 || pick == 0) ? 8 : int'(ptr_ring[$urandom_range(0, lim - 1)]);
         end else if (pick < 18) begin
            fp = (fp & ~7) | $urandom_range(1, 7);
         end else if (pick == 18) begin
            fp = 0;
         end else if (heap_top + 4 <= 4088) begin
            // aligned but past the end marker
            fp = 8 * $urandom_range((heap_top + 11) / 8, 511);
         end else begin
            fp = (fp & ~7) | 4;
         end
      end else begin
         mode = MODE_COALESCE;
      end
      issue(mode, len, fp);
   endtask

   initial begin
      int phase_size [PHASES] = '{256, 4084, 40, 4095, 700, 1800};
      int phase_idle [PHASES] = '{0, 64, 25, 0, 64, 25};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // unformatted heap
      issue(MODE_ALLOC, 16, 0);
      issue(MODE_FREE, 0, 8);
      issue(MODE_COALESCE, 0, 0);
      // heap at the reset size
      issue(MODE_FORMAT, 0, 0);
      issue(MODE_ALLOC, 0, 0);
      issue(MODE_ALLOC, 4095, 0);
      issue(MODE_ALLOC, 4, 0);
      issue(MODE_ALLOC, 100, 0);
      issue(MODE_FREE, 0, 13);
      issue(MODE_FREE, 0, 0);
      issue(MODE_FREE, 0, 8);
      issue(MODE_FREE, 0, 16);
      issue(MODE_COALESCE, 0, 0);
      issue(MODE_ALLOC, 12, 0);
      // stale header inside an allocated block
      issue(MODE_FREE, 0, 16);
      // largest size, clamped heap, exact fit of the whole heap
      write_size(4095);
      issue(MODE_FORMAT, 0, 0);
      issue(MODE_ALLOC, 4084, 0);
      issue(MODE_ALLOC, 0, 0);
      issue(MODE_FREE, 0, 8);
      issue(MODE_COALESCE, 0, 0);
      // smallest heap
      write_size(0);
      issue(MODE_FORMAT, 0, 0);
      issue(MODE_ALLOC, 0, 0);
      issue(MODE_ALLOC, 0, 0);
      issue(MODE_FREE, 0, 16);
      issue(MODE_FREE, 0, 8);
      issue(MODE_ALLOC, 5, 0);

      // random traffic, one heap size and idle mix per phase
      for (int p = 0; p < PHASES; p++) begin
         write_size(phase_size[p]);
         idle_pct = phase_idle[p];
         issue(MODE_FORMAT, $urandom_range(0, 4095), $urandom_range(0, 4095));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 100 || $urandom_range(0, 59) == 0) settle();
            issue_random();
         end
      end

      settle();
      repeat (1100) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("PASS implicit_list_first_fit_allocator_unit");
      end else begin
         $display("FAIL implicit_list_first_fit_allocator_unit");
      end
      $finish;
   end

   // watchdog
   initial begin
      #100_000_000;
      $display("FAIL implicit_list_first_fit_allocator_unit");
      $finish;
   end

endmodule
